/* design/stip_pkg.sv */
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and character constants for the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

  // Configuration port
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned BaseW    = 6;
  localparam logic        REG_BASE = 1'b0;   // word index of base_select

  // Radix limits and fixed radixes
  localparam logic [BaseW-1:0] RADIX_MAX = 6'd36;
  localparam logic [BaseW-1:0] RADIX_ONE = 6'd1;
  localparam logic [BaseW-1:0] RADIX_OCT = 6'd8;
  localparam logic [BaseW-1:0] RADIX_DEC = 6'd10;
  localparam logic [BaseW-1:0] RADIX_HEX = 6'd16;
  localparam logic [BaseW-1:0] RADIX_AUTO = 6'd0;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  // One classified character, as handed from the front to the back
  typedef struct packed {
    logic             start;
    logic             is_digit;  // 0-9, a-z or A-Z
    logic [BaseW-1:0] digit;     // digit value 0..35 when is_digit
    logic             is_space;
    logic             is_plus;
    logic             is_minus;
    logic             is_zero;
    logic             is_x;
  } item_t;

endpackage

/* design/stip_front.sv */
// ----------------------------------------------------------------------------
// stip_front
// Character classifier: turns one input byte into a digit value and flags.
// ----------------------------------------------------------------------------
module stip_front (
  input  logic [7:0]     ch_i,
  input  logic           start_req_i,
  output stip_pkg::item_t item_o
);

  always_comb begin
    item_o          = '0;
    item_o.start    = start_req_i;
    item_o.is_space = (ch_i == stip_pkg::CH_SPACE);
    item_o.is_plus  = (ch_i == stip_pkg::CH_PLUS);
    item_o.is_minus = (ch_i == stip_pkg::CH_MINUS);
    item_o.is_zero  = (ch_i == stip_pkg::CH_ZERO);
    item_o.is_x     = (ch_i == stip_pkg::CH_LO_X);
    if (ch_i inside {[stip_pkg::CH_ZERO:stip_pkg::CH_NINE]}) begin
      item_o.is_digit = 1'b1;
      item_o.digit    = stip_pkg::BaseW'(ch_i - stip_pkg::CH_ZERO);
    end else if (ch_i inside {[stip_pkg::CH_LO_A:stip_pkg::CH_LO_Z]}) begin
      item_o.is_digit = 1'b1;
      item_o.digit    = stip_pkg::BaseW'(ch_i - stip_pkg::CH_LO_A + stip_pkg::LETTER_OFS);
    end else if (ch_i inside {[stip_pkg::CH_UP_A:stip_pkg::CH_UP_Z]}) begin
      item_o.is_digit = 1'b1;
      item_o.digit    = stip_pkg::BaseW'(ch_i - stip_pkg::CH_UP_A + stip_pkg::LETTER_OFS);
    end
  end

endmodule

/* design/stip_queue.sv */
// ----------------------------------------------------------------------------
// stip_queue
// Two-entry flop queue between the classifier and the parse engine.
// ----------------------------------------------------------------------------
module stip_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  stip_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output stip_pkg::item_t rdata_o
);

  stip_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* design/stip_back.sv */
// ----------------------------------------------------------------------------
// stip_back
// Parse engine: sign, prefix and radix resolution, digit multiply-add, and
// the result register.
// ----------------------------------------------------------------------------
module stip_back #(
  parameter int unsigned MAX_LEN = 4096,
  localparam int unsigned PosW   = $clog2(MAX_LEN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [stip_pkg::BaseW-1:0] base_select_i,
  input  logic                       item_valid_i,
  input  stip_pkg::item_t            item_i,
  output logic                       item_take_o,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [63:0]         value_o,
  output logic [PosW-1:0]            end_offset_o,
  output logic                       status_o,
  output logic                       overflow_o
);

  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhPrefix = 2'd1;
  localparam logic [1:0] PhZero   = 2'd2;
  localparam logic [1:0] PhDigits = 2'd3;

  localparam int unsigned BaseW = stip_pkg::BaseW;

  // Parse state
  logic [1:0]       phase_q, phase_d;
  logic [63:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [BaseW-1:0] radix_q, radix_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             wrp_q, wrp_d;
  logic             fin_q, fin_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic [63:0]      value_q;
  logic [PosW-1:0]  offset_q;
  logic             status_q;
  logic             ovf_q;

  // State as seen by this item (start clears it first)
  logic [1:0]       ph;
  logic [63:0]      acc;
  logic             neg;
  logic [BaseW-1:0] rad;
  logic [PosW-1:0]  pos;
  logic             wrp;
  logic             fin;

  logic             bad_base;
  logic [BaseW-1:0] first_radix;
  logic [BaseW-1:0] dig_radix;
  logic             digit_ok;
  logic [69:0]      wide;
  logic [PosW-1:0]  pos_inc;
  logic             take_first;
  logic             take_digit;
  logic             emit;
  logic [63:0]      res_value;
  logic             res_status;
  logic             res_ovf;
  logic             out_free;

  always_comb begin
    ph  = item_i.start ? PhSkip : phase_q;
    acc = item_i.start ? 64'd0 : acc_q;
    neg = item_i.start ? 1'b0 : neg_q;
    rad = item_i.start ? stip_pkg::RADIX_AUTO : radix_q;
    pos = item_i.start ? '0 : pos_q;
    wrp = item_i.start ? 1'b0 : wrp_q;
    fin = item_i.start ? 1'b0 : fin_q;

    bad_base    = (base_select_i == stip_pkg::RADIX_ONE) ||
                  (base_select_i > stip_pkg::RADIX_MAX);
    first_radix = (base_select_i == stip_pkg::RADIX_AUTO) ? stip_pkg::RADIX_DEC
                                                          : base_select_i;
    case (ph)
      PhSkip, PhPrefix: dig_radix = first_radix;
      PhZero:           dig_radix = (rad == stip_pkg::RADIX_AUTO) ? stip_pkg::RADIX_OCT
                                                                  : rad;
      default:          dig_radix = rad;
    endcase

    digit_ok = item_i.is_digit && (item_i.digit < dig_radix);
    wide     = 70'(acc) * 70'(dig_radix) + 70'(item_i.digit);
    pos_inc  = (pos < PosW'(MAX_LEN)) ? pos + PosW'(1) : pos;

    phase_d    = ph;
    acc_d      = acc;
    neg_d      = neg;
    radix_d    = rad;
    pos_d      = pos;
    wrp_d      = wrp;
    fin_d      = fin;
    take_first = 1'b0;
    take_digit = 1'b0;
    emit       = 1'b0;
    res_value  = neg ? (64'd0 - acc) : acc;
    res_status = 1'b0;
    res_ovf    = wrp;

    if (!fin) begin
      case (ph)
        PhSkip: begin
          if (item_i.is_space) begin
            pos_d = pos_inc;
          end else if (item_i.is_plus || item_i.is_minus) begin
            neg_d   = item_i.is_minus;
            pos_d   = pos_inc;
            phase_d = PhPrefix;
          end else begin
            take_first = 1'b1;
          end
        end
        PhPrefix: begin
          take_first = 1'b1;
        end
        PhZero: begin
          if (item_i.is_x) begin
            radix_d = stip_pkg::RADIX_HEX;
            pos_d   = pos_inc;
            phase_d = PhDigits;
          end else begin
            radix_d    = dig_radix;
            take_digit = 1'b1;
          end
        end
        default: begin
          take_digit = 1'b1;
        end
      endcase
    end

    if (take_first) begin
      if (bad_base) begin
        emit       = 1'b1;
        fin_d      = 1'b1;
        res_value  = 64'd0;
        res_status = 1'b1;
        res_ovf    = 1'b0;
      end else if (item_i.is_zero && (base_select_i == stip_pkg::RADIX_AUTO ||
                                      base_select_i == stip_pkg::RADIX_HEX)) begin
        radix_d = base_select_i;
        pos_d   = pos_inc;
        phase_d = PhZero;
      end else begin
        radix_d    = first_radix;
        take_digit = 1'b1;
      end
    end

    if (take_digit) begin
      if (digit_ok) begin
        acc_d   = wide[63:0];
        wrp_d   = wrp || (|wide[69:64]);
        pos_d   = pos_inc;
        phase_d = PhDigits;
      end else begin
        emit  = 1'b1;
        fin_d = 1'b1;
      end
    end
  end

  // Hold the item only when it would produce a result into a full slot
  assign out_free    = !out_valid_q || pop;
  assign item_take_o = item_valid_i && (!emit || out_free);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
    if (item_take_o && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      acc_q       <= 64'd0;
      neg_q       <= 1'b0;
      radix_q     <= stip_pkg::RADIX_AUTO;
      pos_q       <= '0;
      wrp_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_take_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        radix_q <= radix_d;
        pos_q   <= pos_d;
        wrp_q   <= wrp_d;
        fin_q   <= fin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      value_q  <= res_value;
      offset_q <= pos;
      status_q <= res_status;
      ovf_q    <= res_ovf;
    end
  end

  assign empty        = !out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = offset_q;
  assign status_o     = status_q;
  assign overflow_o   = ovf_q;

endmodule

/* design/string_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Parses a signed integer from a character stream, one byte per request.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  chars    | ch_i, start_req_i                       | push / full
//  results  | value_o, end_offset_o, status_o,        | empty / pop
//           | overflow_o                              |
//  config   | psel, penable, pwrite, paddr, pwdata,   | APB write, pready=1
//           | prdata                                  |
//
//  One character per cycle sustained unless stalled: an accepted character is
//  queued, then consumed by the parse engine; a result it ends is registered.
//  The 64x6 multiply-add of the digit path sets the cycle time.
//  Reset clears all parse state and sets base_select to auto-detect.
//  A character that ends a parse waits in the two-entry queue while the
//  result register is still full; full rises once the queue holds two.
// ----------------------------------------------------------------------------
module string_to_integer_parser #(
  parameter int unsigned MAX_LEN = 4096,
  localparam int unsigned PosW   = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // characters
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  ch_i,
  input  logic                        start_req_i,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic signed [63:0]          value_o,
  output logic [PosW-1:0]             end_offset_o,
  output logic                        status_o,
  output logic                        overflow_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stip_pkg::AddrW-1:0]  paddr,
  input  logic [stip_pkg::DataW-1:0]  pwdata,
  output logic [stip_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  logic [stip_pkg::BaseW-1:0] base_q;
  logic                       reg_hit;
  logic                       cfg_wr;
  stip_pkg::item_t            front_item;
  stip_pkg::item_t            q_item;
  logic                       q_valid;
  logic                       q_take;

  // Register file: one register, word index in paddr[2]
  assign reg_hit = (paddr[2] == stip_pkg::REG_BASE);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? stip_pkg::DataW'(base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= stip_pkg::RADIX_AUTO;
    end else if (cfg_wr) begin
      base_q <= pwdata[stip_pkg::BaseW-1:0];
    end
  end

  stip_front u_front (
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .item_o      (front_item)
  );

  stip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (q_take),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  stip_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_select_i (base_q),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_take_o   (q_take),
    .empty         (empty),
    .pop           (pop),
    .value_o       (value_o),
    .end_offset_o  (end_offset_o),
    .status_o      (status_o),
    .overflow_o    (overflow_o)
  );

endmodule
